>>> rtl/tmls_pkg.sv
// tmls_pkg: shared types and constants of the thick midpoint line span unit
// no dependencies; imported by the controller, the datapath and the top level

package tmls_pkg;

	// grid and result limits
	localparam int GRID_SPAN   = 64;
	localparam int MAX_RESULTS = 64;
	localparam int CAP         = (GRID_SPAN < MAX_RESULTS) ? GRID_SPAN : MAX_RESULTS;
	localparam int CNT_W       = $clog2(CAP + 1);

	// field widths
	localparam int COORD_W = 6;
	localparam int ROW_W   = 8;
	localparam int HALF_W  = 5;
	localparam int DEC_W   = 10;

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EMIT
	} tmls_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
	} tmls_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;
	} tmls_status_t;

endpackage

>>> rtl/tmls_cmd_if.sv
// tmls_cmd_if: valid/ready channel that carries one line request
// depends on tmls_pkg for field widths

interface tmls_cmd_if
	import tmls_pkg::*;
	();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] start_x;
	logic [COORD_W-1:0] start_y;
	logic [COORD_W-1:0] end_x;
	logic [COORD_W-1:0] end_y;
	logic [COORD_W-1:0] thickness;

	modport source (output valid, start_x, start_y, end_x, end_y, thickness, input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, thickness, output ready);
endinterface

>>> rtl/tmls_res_if.sv
// tmls_res_if: valid/ready channel that carries one span result
// depends on tmls_pkg for field widths

interface tmls_res_if
	import tmls_pkg::*;
	();
	logic                    valid;
	logic                    ready;
	logic [COORD_W-1:0]      column_x;
	logic signed [ROW_W-1:0] center_y;
	logic signed [ROW_W-1:0] span_low_y;
	logic signed [ROW_W-1:0] span_high_y;
	logic                    status;
	logic                    last_span;

	modport source (output valid, column_x, center_y, span_low_y, span_high_y, status,
		last_span, input ready);
	modport sink (input valid, column_x, center_y, span_low_y, span_high_y, status,
		last_span, output ready);
endinterface

>>> rtl/tmls_ctrl.sv
// tmls_ctrl: request sequencer of the span unit (idle / emit)
// depends on tmls_pkg for the state enum and the command/status structs

module tmls_ctrl
	import tmls_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  tmls_status_t status,
	output tmls_cmd_t    cmd
);

	tmls_state_t state_q;
	tmls_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_ready && status.last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				cmd.step  = out_ready && !status.last;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

>>> rtl/tmls_dp.sv
// tmls_dp: midpoint decision datapath, column walker and span result registers
// depends on tmls_pkg for widths and the command/status structs

module tmls_dp
	import tmls_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  tmls_cmd_t               cmd,
	output tmls_status_t            status,
	input  logic [COORD_W-1:0]      start_x,
	input  logic [COORD_W-1:0]      start_y,
	input  logic [COORD_W-1:0]      end_x,
	input  logic [COORD_W-1:0]      end_y,
	input  logic [COORD_W-1:0]      thickness,
	output logic [COORD_W-1:0]      column_x,
	output logic signed [ROW_W-1:0] center_y,
	output logic signed [ROW_W-1:0] span_low_y,
	output logic signed [ROW_W-1:0] span_high_y,
	output logic                    status_bit,
	output logic                    last_span
);

	localparam logic signed [DEC_W:0] DEC_MAX = (DEC_W + 1)'((1 <<< (DEC_W - 1)) - 1);
	localparam logic signed [DEC_W:0] DEC_MIN = (DEC_W + 1)'(-(1 <<< (DEC_W - 1)));

	function automatic logic signed [DEC_W-1:0] sat_add(logic signed [DEC_W-1:0] a,
		logic signed [DEC_W-1:0] b);
		logic signed [DEC_W:0] sum;
		sum = {a[DEC_W-1], a} + {b[DEC_W-1], b};
		if (sum > DEC_MAX) begin
			return DEC_MAX[DEC_W-1:0];
		end else if (sum < DEC_MIN) begin
			return DEC_MIN[DEC_W-1:0];
		end
		return sum[DEC_W-1:0];
	endfunction

	// walker registers
	logic [COORD_W-1:0]      cur_x_q;
	logic [COORD_W-1:0]      end_col_q;
	logic signed [ROW_W-1:0] cur_y_q;
	logic signed [ROW_W-1:0] low_q;
	logic signed [ROW_W-1:0] high_q;
	logic signed [DEC_W-1:0] decision_q;
	logic signed [DEC_W-1:0] step_east_q;
	logic signed [DEC_W-1:0] step_diag_q;
	logic                    going_down_q;
	logic                    reject_q;
	logic                    last_q;
	logic [CNT_W-1:0]        count_q;

	// setup terms
	logic [COORD_W-1:0]      ady;
	logic                    reject;
	logic                    going_down;
	logic [HALF_W-1:0]       half;
	logic signed [DEC_W-1:0] dx;
	logic signed [DEC_W-1:0] dy;
	logic signed [DEC_W-1:0] sdy;
	logic signed [ROW_W-1:0] y0_row;
	logic signed [ROW_W-1:0] half_row;

	// step terms
	logic                    diag;
	logic signed [ROW_W-1:0] y_inc;
	logic [COORD_W-1:0]      next_x;
	logic [CNT_W-1:0]        next_count;

	always_comb begin
		ady        = (start_y > end_y) ? (start_y - end_y) : (end_y - start_y);
		reject     = !(thickness[0] && (thickness <= ady));
		going_down = (start_x != end_x) && (start_y != end_y)
			&& ((end_x > start_x) != (end_y > start_y));
		half       = thickness[COORD_W-1:1];
		dx         = DEC_W'($signed({1'b0, end_x})) - DEC_W'($signed({1'b0, start_x}));
		dy         = DEC_W'($signed({1'b0, end_y})) - DEC_W'($signed({1'b0, start_y}));
		// negative slope: y deltas negated, which covers both forms with one expression
		sdy        = going_down ? -dy : dy;
		y0_row     = ROW_W'($signed({1'b0, start_y}));
		half_row   = ROW_W'($signed({1'b0, half}));

		diag       = decision_q > 0;
		y_inc      = going_down_q ? -ROW_W'(1) : ROW_W'(1);
		next_x     = cur_x_q + COORD_W'(1);
		next_count = count_q + CNT_W'(1);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= 1'b0;
			count_q <= '0;
		end else if (cmd.load) begin
			last_q  <= reject || (start_x >= end_x) || (CAP == 1);
			count_q <= '0;
		end else if (cmd.step) begin
			last_q  <= (next_x >= end_col_q) || (next_count == CNT_W'(CAP - 1));
			count_q <= next_count;
		end
	end

	// payload state
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			reject_q     <= reject;
			going_down_q <= going_down;
			end_col_q    <= end_x;
			decision_q   <= (sdy <<< 1) - dx;
			step_east_q  <= sdy <<< 1;
			step_diag_q  <= (sdy - dx) <<< 1;
			if (reject) begin
				cur_x_q <= '0;
				cur_y_q <= '0;
				low_q   <= '0;
				high_q  <= '0;
			end else begin
				cur_x_q <= start_x;
				cur_y_q <= y0_row;
				low_q   <= y0_row - half_row;
				high_q  <= y0_row + half_row;
			end
		end else if (cmd.step) begin
			cur_x_q <= next_x;
			if (diag) begin
				decision_q <= sat_add(decision_q, step_diag_q);
				cur_y_q    <= cur_y_q + y_inc;
				low_q      <= low_q + y_inc;
				high_q     <= high_q + y_inc;
			end else begin
				decision_q <= sat_add(decision_q, step_east_q);
			end
		end
	end

	assign status.last = last_q;
	assign column_x    = cur_x_q;
	assign center_y    = cur_y_q;
	assign span_low_y  = low_q;
	assign span_high_y = high_q;
	assign status_bit  = reject_q ? STATUS_REJECT : STATUS_OK;
	assign last_span   = last_q;

endmodule

>>> rtl/thick_midpoint_line_spans_unit.sv
// thick_midpoint_line_spans_unit: top level of the thick midpoint line span unit
// depends on tmls_pkg, tmls_cmd_if, tmls_res_if, tmls_ctrl and tmls_dp
//
//  channel | dir | payload                                                  | handshake
//  --------+-----+----------------------------------------------------------+----------
//  cmd     | in  | start_x, start_y, end_x, end_y, thickness                | valid/ready
//  res     | out | column_x, center_y, span_low_y, span_high_y, status,     | valid/ready
//          |     | last_span                                                |
//
// a request is accepted and its decision terms are loaded in a setup step, then the
// unit emits n columns (n = 1 for a rejected thickness or start_x >= end_x, else
// end_x - start_x + 1, at most 64), set by the single decision accumulator that
// advances one column per delivered result
// cmd.ready is high only in idle; the next request is accepted in the cycle after
// the last result is taken
// a stall on res holds the result registers and the walker where they are
// arst_n returns the sequencer to idle; no clearing pass is needed

module thick_midpoint_line_spans_unit
	import tmls_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	tmls_cmd_if.sink   cmd,
	tmls_res_if.source res
);

	// command and status between sequencer and datapath
	tmls_cmd_t    dp_cmd;
	tmls_status_t dp_status;

	// idle/emit sequencer: owns both handshakes
	tmls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.status    (dp_status),
		.cmd       (dp_cmd)
	);

	// midpoint walker; its registers drive the result payload directly
	tmls_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.status      (dp_status),
		.start_x     (cmd.start_x),
		.start_y     (cmd.start_y),
		.end_x       (cmd.end_x),
		.end_y       (cmd.end_y),
		.thickness   (cmd.thickness),
		.column_x    (res.column_x),
		.center_y    (res.center_y),
		.span_low_y  (res.span_low_y),
		.span_high_y (res.span_high_y),
		.status_bit  (res.status),
		.last_span   (res.last_span)
	);

endmodule

>>> tb/tb_thick_midpoint_line_spans_unit.sv
// tb_thick_midpoint_line_spans_unit: self-checking bench for the thick midpoint line span unit
// depends on tmls_pkg, tmls_cmd_if, tmls_res_if and thick_midpoint_line_spans_unit
// a scripted request table first, then random line requests under four idling phases

module tb_thick_midpoint_line_spans_unit
	import tmls_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// one line request as it travels on the request channel
	typedef struct packed {
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] y0;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y1;
		logic [COORD_W-1:0] thick;
	} line_req_t;

	// one vertical span as it comes back on the result channel
	typedef struct packed {
		logic [COORD_W-1:0]      col;
		logic signed [ROW_W-1:0] center;
		logic signed [ROW_W-1:0] span_lo;
		logic signed [ROW_W-1:0] span_hi;
		logic                    status;
		logic                    last;
	} span_t;

	// scripted request; typed rows carry their single span, the rest go through the predictor
	typedef struct packed {
		line_req_t req;
		logic      typed;
		span_t     span;
	} script_row_t;

	localparam int DEC_HI        = 2 ** (DEC_W - 1) - 1;
	localparam int DEC_LO        = -(2 ** (DEC_W - 1));
	localparam int N_SCRIPT      = 20;
	localparam int N_PHASES      = 4;
	localparam int RAND_PER_PHASE = 22;
	localparam int TAIL_CYCLES   = 80;
	localparam int CYCLE_LIMIT   = 500000;

	// sender idle and receiver stall, in percent per cycle, for each phase
	localparam int IDLE_PCT [N_PHASES]  = '{0, 52, 0, 30};
	localparam int STALL_PCT [N_PHASES] = '{0, 0, 52, 30};

	// a rejected thickness gives one all-zero span with the reject status, marked last
	localparam span_t REJECTED = '{6'd0, 8'sd0, 8'sd0, 8'sd0, STATUS_REJECT, 1'b1};

	localparam script_row_t SCRIPT [N_SCRIPT] = '{
		// thickness zero
		'{'{6'd0, 6'd0, 6'd63, 6'd63, 6'd0}, 1'b1, REJECTED},
		// even thickness
		'{'{6'd0, 6'd0, 6'd63, 6'd63, 6'd2}, 1'b1, REJECTED},
		// thickness above the vertical extent
		'{'{6'd0, 6'd10, 6'd20, 6'd12, 6'd3}, 1'b1, REJECTED},
		// flat line leaves no room for any thickness
		'{'{6'd0, 6'd5, 6'd63, 6'd5, 6'd1}, 1'b1, REJECTED},
		// widest thickness against an extent one short
		'{'{6'd0, 6'd0, 6'd5, 6'd62, 6'd63}, 1'b1, REJECTED},
		// all fields at their top value
		'{'{6'd63, 6'd63, 6'd63, 6'd63, 6'd63}, 1'b1, REJECTED},
		// vertical request, only the start column, span dips below row zero
		'{'{6'd30, 6'd0, 6'd30, 6'd63, 6'd63}, 1'b1,
			'{6'd30, 8'sd0, -8'sd31, 8'sd31, STATUS_OK, 1'b1}},
		// start right of end
		'{'{6'd63, 6'd63, 6'd0, 6'd0, 6'd1}, 1'b1,
			'{6'd63, 8'sd63, 8'sd63, 8'sd63, STATUS_OK, 1'b1}},
		// vertical request at the right edge, span reaches above row 63
		'{'{6'd63, 6'd63, 6'd63, 6'd0, 6'd63}, 1'b1,
			'{6'd63, 8'sd63, 8'sd32, 8'sd94, STATUS_OK, 1'b1}},
		// start right of end with a mid thickness
		'{'{6'd40, 6'd20, 6'd10, 6'd40, 6'd7}, 1'b1,
			'{6'd40, 8'sd20, 8'sd17, 8'sd23, STATUS_OK, 1'b1}},
		// full-width diagonals, both slope forms
		'{'{6'd0, 6'd0, 6'd63, 6'd63, 6'd1}, 1'b0, '0},
		'{'{6'd0, 6'd63, 6'd63, 6'd0, 6'd1}, 1'b0, '0},
		// shallow lines, both slope forms
		'{'{6'd0, 6'd0, 6'd63, 6'd1, 6'd1}, 1'b0, '0},
		'{'{6'd0, 6'd1, 6'd63, 6'd0, 6'd1}, 1'b0, '0},
		// steep lines, the walker climbs at most one row per column
		'{'{6'd0, 6'd0, 6'd1, 6'd63, 6'd61}, 1'b0, '0},
		'{'{6'd0, 6'd63, 6'd1, 6'd0, 6'd33}, 1'b0, '0},
		// widest spans along the diagonals
		'{'{6'd0, 6'd0, 6'd63, 6'd63, 6'd63}, 1'b0, '0},
		'{'{6'd0, 6'd63, 6'd63, 6'd0, 6'd63}, 1'b0, '0},
		// two columns at the right edge
		'{'{6'd62, 6'd0, 6'd63, 6'd63, 6'd1}, 1'b0, '0},
		// ordinary mid-field line
		'{'{6'd10, 6'd20, 6'd50, 6'd40, 6'd5}, 1'b0, '0}
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// request channel drive, registered at the rising edge
	logic      req_valid = 1'b0;
	line_req_t req_line  = '0;
	// result channel ready, registered at the rising edge
	logic      take_span = 1'b0;

	int    sender_idle_pct    = 0;
	int    receiver_stall_pct = 0;
	int    mismatches         = 0;
	int    cycle_count        = 0;
	span_t expected_spans [$];

	tmls_cmd_if line_ch ();
	tmls_res_if span_ch ();

	assign line_ch.valid     = req_valid;
	assign line_ch.start_x   = req_line.x0;
	assign line_ch.start_y   = req_line.y0;
	assign line_ch.end_x     = req_line.x1;
	assign line_ch.end_y     = req_line.y1;
	assign line_ch.thickness = req_line.thick;
	assign span_ch.ready     = take_span;

	thick_midpoint_line_spans_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (line_ch),
		.res    (span_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// decision accumulator is held to the signed range of its register
	function automatic int clamp_decision(input int v);
		if (v > DEC_HI) return DEC_HI;
		if (v < DEC_LO) return DEC_LO;
		return v;
	endfunction

	// walk the line column by column and queue every span it must produce
	task automatic predict_spans(input line_req_t r);
		int    x0, y0, x1, y1, g, ady, half;
		int    col, row, acc, d_east, d_diag, emitted;
		bit    down, more;
		span_t s;
		x0  = int'(r.x0);
		y0  = int'(r.y0);
		x1  = int'(r.x1);
		y1  = int'(r.y1);
		g   = int'(r.thick);
		ady = (y0 > y1) ? (y0 - y1) : (y1 - y0);
		// thickness must be odd and fit inside the vertical extent
		if ((g % 2) == 0 || g > ady) begin
			expected_spans.push_back(REJECTED);
			return;
		end
		half = (g - 1) / 2;
		// negative slope: deltas are taken start minus end and a diagonal step goes down
		down = (x0 != x1) && (y0 != y1) && ((x1 > x0) != (y1 > y0));
		if (down) begin
			acc    = clamp_decision(2 * (y0 - y1) + (x0 - x1));
			d_east = 2 * (y0 - y1);
			d_diag = 2 * ((y0 - y1) + (x0 - x1));
		end else begin
			acc    = clamp_decision(2 * (y1 - y0) - (x1 - x0));
			d_east = 2 * (y1 - y0);
			d_diag = 2 * ((y1 - y0) - (x1 - x0));
		end
		col     = x0;
		row     = y0;
		emitted = 0;
		do begin
			if (emitted > 0) begin
				if (acc <= 0) begin
					acc = clamp_decision(acc + d_east);
				end else begin
					acc = clamp_decision(acc + d_diag);
					row = down ? row - 1 : row + 1;
				end
				col++;
			end
			emitted++;
			// start not left of end stops after the first column; the cap bounds the rest
			more      = (col < x1) && (emitted < CAP);
			s.col     = COORD_W'(col);
			s.center  = ROW_W'(row);
			s.span_lo = ROW_W'(row - half);
			s.span_hi = ROW_W'(row + half);
			s.status  = STATUS_OK;
			s.last    = !more;
			expected_spans.push_back(s);
		end while (more);
	endtask

	// random request: mostly well-formed lines, some with start not left of end, some noise
	function automatic line_req_t random_request();
		line_req_t r;
		int        pick, ady;
		pick = $urandom_range(0, 99);
		r.x0 = COORD_W'($urandom_range(0, 62));
		// short lines dominate, a fair share run long
		if ($urandom_range(0, 1) == 0)
			r.x1 = COORD_W'($urandom_range(int'(r.x0) + 1,
				(int'(r.x0) + 8 > 63) ? 63 : int'(r.x0) + 8));
		else
			r.x1 = COORD_W'($urandom_range(int'(r.x0) + 1, 63));
		do begin
			r.y0 = COORD_W'($urandom);
			r.y1 = COORD_W'($urandom);
		end while (r.y0 == r.y1);
		ady     = (r.y0 > r.y1) ? int'(r.y0) - int'(r.y1) : int'(r.y1) - int'(r.y0);
		r.thick = COORD_W'(2 * $urandom_range(0, (ady + 1) / 2 - 1) + 1);
		if (pick < 6)
			r.x1 = r.x0;
		else if (pick < 14)
			{r.x0, r.x1} = {r.x1, r.x0};
		else if (pick < 30)
			{r.x0, r.y0, r.x1, r.y1, r.thick} = 30'($urandom);
		return r;
	endfunction

	// present one request, hold it until taken, queue its spans, then maybe go idle
	task automatic issue(input line_req_t r, input bit typed, input span_t known);
		req_line  <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!line_ch.ready) @(posedge clk);
		// the request was taken at this edge; its spans come later
		if (typed)
			expected_spans.push_back(known);
		else
			predict_spans(r);
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
		end
	endtask

	// result side: random stall and compare each taken span with the oldest expectation
	always @(posedge clk) begin : span_checker
		span_t got, want;
		take_span <= ($urandom_range(0, 99) >= receiver_stall_pct);
		if (arst_n && span_ch.valid && span_ch.ready) begin
			got = {span_ch.column_x, span_ch.center_y, span_ch.span_low_y,
				span_ch.span_high_y, span_ch.status, span_ch.last_span};
			if (expected_spans.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected span: col %0d center %0d lo %0d hi %0d",
						got.col, got.center, got.span_lo, got.span_hi,
						" st %0b last %0b", got.status, got.last);
			end else begin
				want = expected_spans.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("span mismatch: exp col %0d center %0d lo %0d hi %0d",
							want.col, want.center, want.span_lo, want.span_hi,
							" st %0b last %0b", want.status, want.last);
						$display("  got col %0d center %0d lo %0d hi %0d",
							got.col, got.center, got.span_lo, got.span_hi,
							" st %0b last %0b", got.status, got.last);
					end
				end
			end
		end
	end

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			sender_idle_pct    = IDLE_PCT[ph];
			receiver_stall_pct = STALL_PCT[ph];
			// scripted requests run with no idling on either side
			if (ph == 0)
				for (int i = 0; i < N_SCRIPT; i++)
					issue(SCRIPT[i].req, SCRIPT[i].typed, SCRIPT[i].span);
			for (int i = 0; i < RAND_PER_PHASE; i++)
				issue(random_request(), 1'b0, '0);
			// drop valid and hold off until every span of the phase is back
			req_valid <= 1'b0;
			while (expected_spans.size() != 0) @(posedge clk);
		end

		// let any stray span show up before the verdict
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> thick_midpoint_line_spans_unit.f
rtl/tmls_pkg.sv
rtl/tmls_cmd_if.sv
rtl/tmls_res_if.sv
rtl/tmls_ctrl.sv
rtl/tmls_dp.sv
rtl/thick_midpoint_line_spans_unit.sv
tb/tb_thick_midpoint_line_spans_unit.sv
